/* rtl/emft_pkg.sv */
// ----------------------------------------------------------------------------
// emft_pkg
// Shared types and constants for the exact-match forwarding table: table
// geometry, entry layout, sequencer states and register indexes.
// ----------------------------------------------------------------------------
package emft_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SCAN_W      = CNT_W + 1;

    // Field widths
    localparam int ADDR_W  = 16;
    localparam int HOP_W   = 8;
    localparam int DELAY_W = 16;
    localparam int COUNT_W = 5;

    // Bus widths
    localparam int S_DATA_W = 40;   // dest_address, entry_next_hop, entry_delay
    localparam int M_DATA_W = 32;   // six result fields, 32 bits exactly
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // Operation codes (carried in s_tuser)
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_DEF_HOP   = 2'd0;
    localparam logic [1:0] REG_DEF_VALID = 2'd1;
    localparam logic [1:0] REG_DEF_DELAY = 2'd2;

    // One stored table entry
    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [HOP_W-1:0]   hop;
        logic [ADDR_W-1:0]  addr;
    } entry_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } state_t;

endpackage

/* rtl/exact_match_forwarding_table_core.sv */
// ----------------------------------------------------------------------------
// exact_match_forwarding_table_core
// Exact-match forwarding table with a default route for lookup misses.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one transaction per lookup or insert. s_tuser holds
//   the operation, s_tdata the address, next hop and delay of a new entry.
//   Result stream (m_*): exactly one transaction per input transaction.
//   APB port: default next hop, default-valid flag and default delay; write
//   it only while no transaction is in flight.
// Timing:
//   An item is taken in the idle state, then the sequencer scans the filled
//   entries through the table RAM's single read port, one entry per cycle,
//   with each compare in the cycle after its read. A scan ends at the first
//   match or after the last filled entry; an accepted insert is written in
//   that final cycle, when the result register is also loaded. m_tvalid
//   then rises in the response state, and the next input is accepted in
//   the cycle after the result has been taken.
//   s_tready stays low from acceptance until the result has been taken, so
//   a stalled receiver simply holds the block in the response state.
// Reset: fill count cleared (empty table), default route registers zeroed.
// ----------------------------------------------------------------------------
module exact_match_forwarding_table_core (
    input  logic                          aclk,
    input  logic                          aresetn,

    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [emft_pkg::S_DATA_W-1:0] s_tdata,  // [15:0] dest_address,
                                                    // [23:16] entry_next_hop,
                                                    // [39:24] entry_delay
    input  logic                          s_tuser,  // [0] operation

    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [emft_pkg::M_DATA_W-1:0] m_tdata,  // [0] insert_ok, [1] hit,
                                                    // [9:2] next_hop,
                                                    // [10] next_hop_valid,
                                                    // [26:11] hop_delay,
                                                    // [31:27] entry_count

    // Configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [emft_pkg::APB_AW-1:0]   paddr,
    input  logic [emft_pkg::APB_DW-1:0]   pwdata,
    output logic [emft_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    emft_pkg::state_t state_reg, state_next;

    logic                          op_reg;
    logic [emft_pkg::ADDR_W-1:0]   key_reg;
    logic [emft_pkg::HOP_W-1:0]    hop_in_reg;
    logic [emft_pkg::DELAY_W-1:0]  delay_in_reg;

    logic [emft_pkg::CNT_W-1:0]    fill_count_reg, fill_count_next;
    logic [emft_pkg::IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic                          rd_active_reg, rd_active_next;
    logic                          cmp_valid_reg, cmp_valid_next;
    logic                          cmp_last_reg, cmp_last_next;

    logic                          out_ok_reg, out_ok_next;
    logic                          out_hit_reg, out_hit_next;
    logic [emft_pkg::HOP_W-1:0]    out_hop_reg, out_hop_next;
    logic                          out_valid_reg, out_valid_next;
    logic [emft_pkg::DELAY_W-1:0]  out_delay_reg, out_delay_next;
    logic [emft_pkg::COUNT_W-1:0]  out_count_reg, out_count_next;

    logic [emft_pkg::HOP_W-1:0]    def_hop_reg;
    logic                          def_valid_reg;
    logic [emft_pkg::DELAY_W-1:0]  def_delay_reg;

    logic                          in_fire;
    logic                          out_fire;
    logic                          cfg_wr;
    logic [1:0]                    cfg_idx;
    logic                          rd_en;
    logic                          rd_is_last;
    logic                          match;
    logic                          scan_miss;
    logic                          scan_done;
    logic                          table_full;
    logic                          do_insert;
    emft_pkg::entry_t              rd_entry;
    emft_pkg::entry_t              wr_entry;

    // ------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            def_hop_reg   <= '0;
            def_valid_reg <= 1'b0;
            def_delay_reg <= '0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                emft_pkg::REG_DEF_HOP:   def_hop_reg   <= pwdata[emft_pkg::HOP_W-1:0];
                emft_pkg::REG_DEF_VALID: def_valid_reg <= pwdata[0];
                emft_pkg::REG_DEF_DELAY: def_delay_reg <= pwdata[emft_pkg::DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            emft_pkg::REG_DEF_HOP:   prdata = emft_pkg::APB_DW'(def_hop_reg);
            emft_pkg::REG_DEF_VALID: prdata = emft_pkg::APB_DW'(def_valid_reg);
            emft_pkg::REG_DEF_DELAY: prdata = emft_pkg::APB_DW'(def_delay_reg);
            default:                 prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Table RAM: at most one read per scan cycle, write at the end of an insert
    // ------------------------------------------------------------------
    assign wr_entry.addr  = key_reg;
    assign wr_entry.hop   = hop_in_reg;
    assign wr_entry.delay = delay_in_reg;

    emft_ram #(
        .WIDTH ($bits(emft_pkg::entry_t)),
        .DEPTH (emft_pkg::TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (do_insert),
        .wr_addr (fill_count_reg[emft_pkg::IDX_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_entry)
    );

    // ------------------------------------------------------------------
    // Scan status
    // ------------------------------------------------------------------
    assign rd_is_last = (emft_pkg::SCAN_W'(rd_idx_reg) + emft_pkg::SCAN_W'(1))
                        == emft_pkg::SCAN_W'(fill_count_reg);
    assign match      = cmp_valid_reg && (rd_entry.addr == key_reg);
    // empty table misses at once; otherwise miss after the last entry compares
    assign scan_miss  = (cmp_valid_reg && cmp_last_reg && !match)
                        || (fill_count_reg == '0);
    assign scan_done  = (state_reg == emft_pkg::ST_SCAN) && (match || scan_miss);
    assign table_full = fill_count_reg == emft_pkg::CNT_W'(emft_pkg::TABLE_DEPTH);
    assign do_insert  = scan_done && (op_reg == emft_pkg::OP_INSERT)
                        && !match && !table_full;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            emft_pkg::ST_IDLE: if (in_fire)   state_next = emft_pkg::ST_SCAN;
            emft_pkg::ST_SCAN: if (scan_done) state_next = emft_pkg::ST_RESP;
            emft_pkg::ST_RESP: if (out_fire)  state_next = emft_pkg::ST_IDLE;
            default:                          state_next = emft_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        rd_en    = 1'b0;
        case (state_reg)
            emft_pkg::ST_IDLE: s_tready = 1'b1;
            emft_pkg::ST_SCAN: rd_en    = rd_active_reg;
            emft_pkg::ST_RESP: m_tvalid = 1'b1;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb begin
        rd_idx_next     = rd_idx_reg;
        rd_active_next  = rd_active_reg;
        cmp_valid_next  = 1'b0;
        cmp_last_next   = cmp_last_reg;
        fill_count_next = fill_count_reg;
        out_ok_next     = out_ok_reg;
        out_hit_next    = out_hit_reg;
        out_hop_next    = out_hop_reg;
        out_valid_next  = out_valid_reg;
        out_delay_next  = out_delay_reg;
        out_count_next  = out_count_reg;

        // start a scan from slot zero
        if (in_fire) begin
            rd_idx_next    = '0;
            rd_active_next = 1'b1;
            cmp_last_next  = 1'b0;
        end

        // issue a read; its compare follows next cycle
        if (rd_en) begin
            rd_idx_next    = rd_idx_reg + emft_pkg::IDX_W'(1);
            rd_active_next = !rd_is_last;
            cmp_valid_next = 1'b1;
            cmp_last_next  = rd_is_last;
        end

        // resolve the item and load the result register
        if (scan_done) begin
            rd_active_next = 1'b0;
            cmp_valid_next = 1'b0;
            if (do_insert) begin
                fill_count_next = fill_count_reg + emft_pkg::CNT_W'(1);
            end
            if (op_reg == emft_pkg::OP_INSERT) begin
                out_ok_next    = do_insert;
                out_hit_next   = 1'b0;
                out_hop_next   = '0;
                out_valid_next = 1'b0;
                out_delay_next = '0;
            end else if (match) begin
                out_ok_next    = 1'b0;
                out_hit_next   = 1'b1;
                out_hop_next   = rd_entry.hop;
                out_valid_next = 1'b1;
                out_delay_next = rd_entry.delay;
            end else begin
                out_ok_next    = 1'b0;
                out_hit_next   = 1'b0;
                out_hop_next   = def_hop_reg;
                out_valid_next = def_valid_reg;
                out_delay_next = def_delay_reg;
            end
            out_count_next = emft_pkg::COUNT_W'(fill_count_next);
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= emft_pkg::ST_IDLE;
            fill_count_reg <= '0;
            rd_active_reg  <= 1'b0;
            cmp_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            rd_active_reg  <= rd_active_next;
            cmp_valid_reg  <= cmp_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            op_reg       <= s_tuser;
            key_reg      <= s_tdata[15:0];
            hop_in_reg   <= s_tdata[23:16];
            delay_in_reg <= s_tdata[39:24];
        end
        rd_idx_reg    <= rd_idx_next;
        cmp_last_reg  <= cmp_last_next;
        out_ok_reg    <= out_ok_next;
        out_hit_reg   <= out_hit_next;
        out_hop_reg   <= out_hop_next;
        out_valid_reg <= out_valid_next;
        out_delay_reg <= out_delay_next;
        out_count_reg <= out_count_next;
    end

    // Result packing
    assign m_tdata = {out_count_reg, out_delay_reg, out_valid_reg,
                      out_hop_reg, out_hit_reg, out_ok_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the fill count never exceeds the table depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        emft_pkg::SCAN_W'(fill_count_reg) <= emft_pkg::SCAN_W'(emft_pkg::TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // the fill count moves only by one, at the end of a scan
    a_fill_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && !$stable(fill_count_reg)) |->
            ($past(state_reg) == emft_pkg::ST_SCAN
             && fill_count_reg == $past(fill_count_reg) + emft_pkg::CNT_W'(1)))
        else $error("fill count changed outside an insert");

    // input and result sides are never open together
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    // a result never reports both an accepted insert and a hit
    a_ok_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(out_ok_reg && out_hit_reg))
        else $error("insert_ok and hit both set");

    // compares happen only during a scan
    a_cmp_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_valid_reg |-> (state_reg == emft_pkg::ST_SCAN))
        else $error("compare outside the scan state");

endmodule

/* rtl/emft_ram.sv */
// ----------------------------------------------------------------------------
// emft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module emft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        aclk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic                                        rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
